[rtl/core/svs_pkg.sv]
// Shared types and constants for the solenoid valve sequencer.
package svs_pkg;

   // Bank size and fixed field widths
   localparam int unsigned VALVE_COUNT = 8;
   localparam int unsigned PIN_BITS    = 8;
   localparam int unsigned TIMER_BITS  = 17;
   localparam int unsigned TICK_BITS   = 16;
   localparam logic [4:0]  VALVE_LIMIT = 5'(VALVE_COUNT);

   // Valve commands
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_CLOSE = 2'd1;
   localparam logic [1:0] CMD_OPEN  = 2'd2;
   localparam logic [1:0] CMD_PULSE = 2'd3;

   // Item actions
   localparam logic ACT_COMMAND = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   // Register indexes
   localparam logic [1:0] REG_NC_MASK     = 2'd0;
   localparam logic [1:0] REG_PULSE_TICKS = 2'd1;
   localparam logic [1:0] REG_OPEN_TICKS  = 2'd2;
   localparam logic [1:0] REG_CLOSE_TICKS = 2'd3;

   typedef struct packed {
      logic       action;
      logic [3:0] valve_index;
      logic [1:0] command;
   } req_type;

   typedef struct packed {
      logic [7:0] drive_levels;
      logic [7:0] open_states;
      logic       addressed_open;
      logic [1:0] addressed_command;
      logic       index_valid;
   } rsp_type;

   // Beat travelling down the row of cells
   typedef struct packed {
      logic    valid;
      req_type req;
      rsp_type rsp;
   } svs_beat_type;

   // Timing registers shared by every cell
   typedef struct packed {
      logic [TICK_BITS-1:0] pulse_ticks;
      logic [TICK_BITS-1:0] special_open_ticks;
      logic [TICK_BITS-1:0] special_close_ticks;
   } svs_cfg_type;

endpackage

[rtl/core/svs_cell.sv]
// One valve cell: holds the valve state and forwards the beat to its neighbor.
module svs_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [3:0]           cell_index,
   input  logic                 nc,
   input  svs_pkg::svs_cfg_type cfg,
   input  svs_pkg::svs_beat_type beat_in,
   output svs_pkg::svs_beat_type beat_out
);
   import svs_pkg::*;

   logic [1:0]            cmd_ff, cmd_in;
   logic                  open_ff, open_in;
   logic                  pin_ff, pin_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  phase_ff, phase_in;
   logic                  beat_valid_ff;
   svs_beat_type          beat_ff, beat_in_next;
   logic                  hit;

   assign hit = (beat_in.req.valve_index == cell_index);

   // Compute the valve's next state for the incoming beat
   always_comb begin
      cmd_in   = cmd_ff;
      open_in  = open_ff;
      pin_in   = pin_ff;
      timer_in = timer_ff;
      phase_in = phase_ff;
      if (beat_in.valid) begin
         if (beat_in.req.action == ACT_COMMAND) begin
            if (hit) begin
               cmd_in   = beat_in.req.command;
               timer_in = '0;
               unique case (beat_in.req.command)
                  CMD_OPEN, CMD_PULSE: begin
                     open_in  = 1'b1;
                     pin_in   = nc;
                     phase_in = 1'b1;
                  end
                  CMD_CLOSE: begin
                     open_in  = 1'b0;
                     pin_in   = ~nc;
                     phase_in = 1'b0;
                  end
                  default: begin
                     phase_in = 1'b0;
                  end
               endcase
            end
         end else begin
            // advance the timer, saturating
            if (timer_ff != {TIMER_BITS{1'b1}}) begin
               timer_in = timer_ff + 1'b1;
            end
            // close an expired pulse
            if ((cmd_ff == CMD_PULSE) && (timer_in > {1'b0, cfg.pulse_ticks})) begin
               cmd_in   = CMD_CLOSE;
               timer_in = '0;
               open_in  = 1'b0;
               pin_in   = ~nc;
               phase_in = 1'b0;
            end
            // alternate the pin of a venting normally closed valve
            if ((cmd_ff == CMD_OPEN) && nc) begin
               if (phase_ff) begin
                  if (timer_in > {1'b0, cfg.special_open_ticks}) begin
                     pin_in   = 1'b0;
                     timer_in = '0;
                     phase_in = 1'b0;
                  end
               end else if (timer_in > {1'b0, cfg.special_close_ticks}) begin
                  pin_in   = 1'b1;
                  timer_in = '0;
                  phase_in = 1'b1;
               end
            end
         end
      end
   end

   // Merge this valve's bits into the beat
   always_comb begin
      beat_in_next = beat_in;
      if (cell_index < 4'd8) begin
         beat_in_next.rsp.drive_levels[cell_index[2:0]] = pin_in;
         beat_in_next.rsp.open_states[cell_index[2:0]]  = open_in;
      end
      if (hit) begin
         beat_in_next.rsp.addressed_open    = open_in;
         beat_in_next.rsp.addressed_command = cmd_in;
      end
   end

   // Hold state while stalled, update on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= CMD_NONE;
         open_ff       <= 1'b1;
         pin_ff        <= 1'b0;
         timer_ff      <= {TIMER_BITS{1'b1}};
         phase_ff      <= 1'b0;
         beat_valid_ff <= 1'b0;
      end else if (advance) begin
         cmd_ff        <= cmd_in;
         open_ff       <= open_in;
         pin_ff        <= pin_in;
         timer_ff      <= timer_in;
         phase_ff      <= phase_in;
         beat_valid_ff <= beat_in.valid;
      end
   end

   // Beat payload needs no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in_next;
      end
   end

   always_comb begin
      beat_out       = beat_ff;
      beat_out.valid = beat_valid_ff;
   end

endmodule

[rtl/core/solenoid_valve_sequencer_core.sv]
// Top level of the solenoid valve sequencer: registers and the row of valve cells.
//
//  channel | direction | handshake             | beat
//  req     | in        | req_valid / req_ready | req_data (action, index, command)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (levels, opens, addressed)
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// An item walks the row one cell per cycle while the row advances, and a new item
// enters every cycle that the row advances, since each cell sees the items in order.
// The last cell's stage is the result register; the whole row holds while it is full
// and not taken. Reset restores every valve; csr writes are always taken.
module solenoid_valve_sequencer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  svs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output svs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import svs_pkg::*;

   logic [PIN_BITS-1:0]  nc_mask_ff;
   logic [TICK_BITS-1:0] pulse_ticks_ff;
   logic [TICK_BITS-1:0] open_ticks_ff;
   logic [TICK_BITS-1:0] close_ticks_ff;
   svs_cfg_type          cfg;
   svs_beat_type         beat [VALVE_COUNT+1];
   logic                 advance;

   // Write configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         nc_mask_ff     <= '0;
         pulse_ticks_ff <= 16'd100;
         open_ticks_ff  <= 16'd100;
         close_ticks_ff <= 16'd100;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_NC_MASK:     nc_mask_ff     <= csr_data[PIN_BITS-1:0];
            REG_PULSE_TICKS: pulse_ticks_ff <= csr_data;
            REG_OPEN_TICKS:  open_ticks_ff  <= csr_data;
            REG_CLOSE_TICKS: close_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.pulse_ticks         = pulse_ticks_ff;
   assign cfg.special_open_ticks  = open_ticks_ff;
   assign cfg.special_close_ticks = close_ticks_ff;

   // Shift the whole row unless the result stage is stuck
   assign advance   = ~beat[VALVE_COUNT].valid | rsp_ready;
   assign req_ready = advance;

   // Build the entry beat with an empty result but for index_valid
   always_comb begin
      beat[0].valid                 = req_valid;
      beat[0].req                   = req_data;
      beat[0].rsp.drive_levels      = '0;
      beat[0].rsp.open_states       = '0;
      beat[0].rsp.addressed_open    = 1'b0;
      beat[0].rsp.addressed_command = CMD_NONE;
      beat[0].rsp.index_valid       = ({1'b0, req_data.valve_index} < VALVE_LIMIT);
   end

   // Row of valve cells
   for (genvar v = 0; v < VALVE_COUNT; v++) begin : g_cell
      logic nc;
      if (v < PIN_BITS) begin : g_nc
         assign nc = nc_mask_ff[v];
      end else begin : g_no
         assign nc = 1'b0;
      end
      svs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (4'(v)),
         .nc         (nc),
         .cfg        (cfg),
         .beat_in    (beat[v]),
         .beat_out   (beat[v+1])
      );
   end

   assign rsp_valid = beat[VALVE_COUNT].valid;
   assign rsp_data  = beat[VALVE_COUNT].rsp;

   // Checks
   a_index_valid: assert property (@(posedge clock) disable iff (reset)
      beat[VALVE_COUNT].valid |->
         beat[VALVE_COUNT].rsp.index_valid ==
            ({1'b0, beat[VALVE_COUNT].req.valve_index} < VALVE_LIMIT))
      else $error("index_valid does not match the carried valve index");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.index_valid) |->
         (!rsp_data.addressed_open && rsp_data.addressed_command == CMD_NONE))
      else $error("addressed fields set for an invalid valve index");

   a_entry_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> beat[1].valid)
      else $error("accepted beat did not reach the first cell");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

[bench/solenoid_valve_sequencer_core_tb.sv]
// Testbench for the solenoid valve sequencer core: command and tick beats against a bank model.
`timescale 1ns / 1ps

module solenoid_valve_sequencer_core_tb;
   import svs_pkg::*;

   localparam int unsigned IDLE_LIMIT  = 1000;
   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned PHASE_BEATS = 116;

   // Valve bank prediction and response checking
   class valve_bank_scoreboard;
      logic [7:0]            nc_mask;
      logic [TICK_BITS-1:0]  pulse_ticks;
      logic [TICK_BITS-1:0]  open_ticks;
      logic [TICK_BITS-1:0]  close_ticks;
      logic [1:0]            command_q    [VALVE_COUNT];
      bit                    open_q       [VALVE_COUNT];
      bit                    pin_q        [VALVE_COUNT];
      logic [TIMER_BITS-1:0] elapsed_q    [VALVE_COUNT];
      bit                    high_phase_q [VALVE_COUNT];
      rsp_type               pending_status_q [$];
      int unsigned           mismatch_count;

      function new();
         nc_mask        = '0;
         pulse_ticks    = 16'd100;
         open_ticks     = 16'd100;
         close_ticks    = 16'd100;
         mismatch_count = 0;
         for (int v = 0; v < VALVE_COUNT; v++) begin
            command_q[v]    = CMD_NONE;
            open_q[v]       = 1'b1;
            pin_q[v]        = 1'b0;
            elapsed_q[v]    = '1;
            high_phase_q[v] = 1'b0;
         end
      endfunction

      function void load_register(logic [1:0] idx, logic [15:0] value);
         case (idx)
            REG_NC_MASK:     nc_mask     = value[7:0];
            REG_PULSE_TICKS: pulse_ticks = value;
            REG_OPEN_TICKS:  open_ticks  = value;
            REG_CLOSE_TICKS: close_ticks = value;
         endcase
      endfunction

      // Apply one command to a valve: restart its timer and set its phase
      function void actuate(int v, logic [1:0] cmd);
         bit nc;
         nc = (v < PIN_BITS) && nc_mask[v];
         command_q[v] = cmd;
         elapsed_q[v] = '0;
         case (cmd)
            CMD_OPEN, CMD_PULSE: begin
               open_q[v]       = 1'b1;
               pin_q[v]        = nc;
               high_phase_q[v] = 1'b1;
            end
            CMD_CLOSE: begin
               open_q[v]       = 1'b0;
               pin_q[v]        = !nc;
               high_phase_q[v] = 1'b0;
            end
            default: begin
               high_phase_q[v] = 1'b0;
            end
         endcase
      endfunction

      function void note_request(req_type item);
         rsp_type status;
         int      idx;
         bit      in_range;
         idx      = item.valve_index;
         in_range = (idx < VALVE_COUNT);
         if (item.action == ACT_COMMAND) begin
            if (in_range) actuate(idx, item.command);
         end else begin
            // Advance every timer, close expired pulses, toggle venting NC valves
            for (int v = 0; v < VALVE_COUNT; v++) begin
               if (elapsed_q[v] != '1) elapsed_q[v] = elapsed_q[v] + 1'b1;
               if (command_q[v] == CMD_PULSE && elapsed_q[v] > {1'b0, pulse_ticks})
                  actuate(v, CMD_CLOSE);
               if (command_q[v] == CMD_OPEN && (v < PIN_BITS) && nc_mask[v]) begin
                  if (high_phase_q[v]) begin
                     if (elapsed_q[v] > {1'b0, open_ticks}) begin
                        pin_q[v]        = 1'b0;
                        elapsed_q[v]    = '0;
                        high_phase_q[v] = 1'b0;
                     end
                  end else if (elapsed_q[v] > {1'b0, close_ticks}) begin
                     pin_q[v]        = 1'b1;
                     elapsed_q[v]    = '0;
                     high_phase_q[v] = 1'b1;
                  end
               end
            end
         end
         status = '0;
         for (int v = 0; v < VALVE_COUNT && v < PIN_BITS; v++) begin
            status.drive_levels[v] = pin_q[v];
            status.open_states[v]  = open_q[v];
         end
         if (in_range) begin
            status.addressed_open    = open_q[idx];
            status.addressed_command = command_q[idx];
            status.index_valid       = 1'b1;
         end
         // Append the expected beat at the tail
         pending_status_q = {pending_status_q, status};
      endfunction

      function void note_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function void compare_field(string name, logic [7:0] expected, logic [7:0] actual);
         if (actual !== expected)
            note_mismatch($sformatf("%s expected %h got %h", name, expected, actual));
      endfunction

      function void check_status(rsp_type actual);
         rsp_type expected;
         if (pending_status_q.size() == 0) begin
            note_mismatch($sformatf("unexpected response beat %p", actual));
            return;
         end
         expected = pending_status_q.pop_front();
         compare_field("drive_levels", expected.drive_levels, actual.drive_levels);
         compare_field("open_states", expected.open_states, actual.open_states);
         compare_field("addressed_open", 8'(expected.addressed_open),
                       8'(actual.addressed_open));
         compare_field("addressed_command", 8'(expected.addressed_command),
                       8'(actual.addressed_command));
         compare_field("index_valid", 8'(expected.index_valid), 8'(actual.index_valid));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_NC_MASK;
   logic [15:0] csr_data = '0;

   valve_bank_scoreboard sb = new();
   bit                   send_burst = 1'b0;

   solenoid_valve_sequencer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic req_type make_request(logic action, logic [3:0] idx, logic [1:0] cmd);
      req_type item;
      item.action      = action;
      item.valve_index = idx;
      item.command     = cmd;
      return item;
   endfunction

   // Mostly ticks and commands to real valves, some commands to missing valves
   function automatic req_type random_request();
      req_type     item;
      int unsigned pick;
      pick             = $urandom_range(0, 99);
      item.command     = 2'($urandom_range(0, 3));
      item.valve_index = 4'($urandom_range(0, VALVE_COUNT - 1));
      item.action      = ACT_COMMAND;
      if (pick < 52) begin
         item.action      = ACT_TICK;
         item.valve_index = 4'($urandom_range(0, 15));
      end else if (pick >= 92) begin
         item.valve_index = 4'($urandom_range(VALVE_COUNT, 15));
      end
      return item;
   endfunction

   // Drive one request beat after a random gap; hold it until taken
   task automatic send_request(input req_type item);
      int unsigned gap;
      if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   // Drop valid and hold until every response has come back
   task automatic drain_bank();
      req_valid <= 1'b0;
      while (sb.pending_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic program_bank(input logic [15:0] nc_word, input logic [15:0] pulse,
                               input logic [15:0] open_t, input logic [15:0] close_t);
      logic [15:0] values [4];
      values[REG_NC_MASK]     = nc_word;
      values[REG_PULSE_TICKS] = pulse;
      values[REG_OPEN_TICKS]  = open_t;
      values[REG_CLOSE_TICKS] = close_t;
      for (int r = 0; r < 4; r++) begin
         csr_valid <= 1'b1;
         csr_index <= 2'(r);
         csr_data  <= values[r];
         do @(posedge clock); while (!csr_ready);
         sb.load_register(2'(r), values[r]);
      end
      csr_valid <= 1'b0;
   endtask

   // Response side: random stalls, with bursts of no stalls
   initial begin
      int unsigned stall;
      bit          rsp_burst;
      rsp_burst = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_status(rsp_data);
      end
   end

   // Watchdog: end the run when no channel moves a beat for too long
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL solenoid_valve_sequencer_core");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: saturated timers, missing valves, a tick with a bad index
      send_request(make_request(ACT_TICK, 4'd0, CMD_NONE));
      send_request(make_request(ACT_COMMAND, 4'd15, CMD_OPEN));
      send_request(make_request(ACT_COMMAND, 4'd8, CMD_PULSE));
      send_request(make_request(ACT_TICK, 4'd12, CMD_CLOSE));
      send_request(make_request(ACT_COMMAND, 4'd0, CMD_NONE));
      drain_bank();

      // Short timers: open, pulse and close on NC and NO valves, pulse expiry, vent toggling
      program_bank(16'h5A0F, 16'd1, 16'd0, 16'd2);
      send_request(make_request(ACT_COMMAND, 4'd0, CMD_OPEN));
      send_request(make_request(ACT_COMMAND, 4'd4, CMD_OPEN));
      send_request(make_request(ACT_COMMAND, 4'd1, CMD_PULSE));
      send_request(make_request(ACT_COMMAND, 4'd5, CMD_PULSE));
      send_request(make_request(ACT_COMMAND, 4'd2, CMD_CLOSE));
      send_request(make_request(ACT_COMMAND, 4'd6, CMD_CLOSE));
      send_request(make_request(ACT_TICK, 4'd0, CMD_NONE));
      send_request(make_request(ACT_TICK, 4'd1, CMD_NONE));
      send_request(make_request(ACT_TICK, 4'd5, CMD_NONE));
      send_request(make_request(ACT_TICK, 4'd0, CMD_NONE));
      send_request(make_request(ACT_COMMAND, 4'd3, CMD_NONE));
      send_request(make_request(ACT_COMMAND, 4'd7, CMD_OPEN));
      send_request(make_request(ACT_TICK, 4'd7, CMD_PULSE));

      // Random phases, each under its own register settings
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_bank();
         case (phase)
            0: program_bank(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            1: program_bank(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: program_bank(16'h00F0, 16'd3, 16'd0, 16'd1);
            default: program_bank(16'($urandom), 16'($urandom_range(0, 8)),
                                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) send_request(random_request());
      end

      drain_bank();
      repeat (VALVE_COUNT + 4) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending_status_q.size() == 0) begin
         $display("PASS solenoid_valve_sequencer_core");
      end else begin
         $display("FAIL solenoid_valve_sequencer_core");
      end
      $finish;
   end

endmodule
